[sv/abv_pkg.sv]
`timescale 1ns / 1ps
// shared constants and the cordic step-angle table for the vector angle pipeline
package abv_pkg;

  // coordinate and angle formats
  localparam int COORD_BITS      = 32;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 16;

  // scaling of vectors ahead of the products
  localparam int NORM_BITS = 30;

  // square root and cordic depth
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_ITERS = 36;
  localparam int ANG_SCALE    = 36;
  localparam int PRESCALE     = 20;

  // angle accumulator, radians scaled by 2^ANG_SCALE
  localparam int ANG_W = 40;
  localparam int PI_W  = 38;
  localparam logic [PI_W-1:0] PI_S      = 38'h3243F6A888;
  localparam logic [PI_W-1:0] HALF_PI_S = 38'h1921FB5444;

  // radians to output units
  localparam int DEG_SCALE = 180 << ANGLE_FRAC_BITS;
  localparam int DEG_W     = $clog2(DEG_SCALE + 1);

  // atan(2^-i) scaled by 2^ANG_SCALE, rounded to nearest
  function automatic logic [ANG_W-1:0] step_angle(input int unsigned i);
    logic [ANG_W-1:0] v;
    case (i)
      0:       v = 40'h0C90FDAA22;
      1:       v = 40'd31861621080;
      2:       v = 40'd16834805542;
      3:       v = 40'd8545610155;
      4:       v = 40'd4289387961;
      5:       v = 40'd2146785007;
      6:       v = 40'd1073654455;
      7:       v = 40'd536859990;
      8:       v = 40'd268434091;
      9:       v = 40'd134217557;
      10:      v = 40'd67108843;
      11:      v = 40'd33554429;
      default: v = ANG_W'(64'd1 << (ANG_SCALE - i));
    endcase
    return v;
  endfunction

endpackage

[sv/angle_between_vectors.sv]
`timescale 1ns / 1ps
// angle between a heading and the vector to a target, in 1/256 degree
//
//   channel   ports                                   direction
//   input     in_valid, in_stall, in_pos_*, in_dir_*,  in
//             in_target_*
//   result    out_valid, out_stall, out_angle_deg,     out
//             out_degenerate
//
// one transaction enters per cycle while the pipeline is not stalled; the depth is set by the 32 square
// root stages, the 36 cordic stages and 15 stages of scaling, products, fold,
// clamp and the reciprocal conversion to degrees.
// rst_n (synchronous, active low) clears only the stage valid bits.
// a stall on the result side freezes the whole pipeline; in_stall is high
// exactly while a finished result waits and out_stall is high.
module angle_between_vectors
  import abv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic signed [COORD_BITS-1:0] in_dir_x,
  input  logic signed [COORD_BITS-1:0] in_dir_y,
  input  logic signed [COORD_BITS-1:0] in_dir_z,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  input  logic signed [COORD_BITS-1:0] in_target_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ANGLE_W-1:0]           out_angle_deg,
  output logic                         out_degenerate
);

  localparam int CW         = COORD_BITS;
  localparam int BW         = CW + 1;
  localparam int SW         = NORM_BITS + 1;
  localparam int PW         = 2 * SW;
  localparam int WW         = 2 * SW + 1;
  localparam int WMW        = WW - 1;
  localparam int MW         = 64;
  localparam int SH_W       = $clog2(MW);
  localparam int SQW        = 2 * NORM_BITS;
  localparam int RTW        = 2 * NORM_BITS + 3;
  localparam int YW         = NORM_BITS + 1;
  localparam int CDW        = NORM_BITS + PRESCALE + 6;
  localparam int NW         = PI_W + DEG_W;
  localparam int CNV_STAGES = 4;
  localparam int NST        = 8 + 1 + SQRT_STEPS + 1 + CORDIC_ITERS + 1 + CNV_STAGES;

  // shift that brings the largest magnitude below 2^NORM_BITS
  function automatic logic [SH_W-1:0] norm_shift(input logic [MW-1:0] m);
    logic [SH_W-1:0] s;
    s = '0;
    for (int i = NORM_BITS; i < MW; i++) begin
      if (m[i]) s = SH_W'(i - NORM_BITS + 1);
    end
    return s;
  endfunction

  // pipeline advance and stage valid bits
  logic           en;
  logic [NST-1:0] vld_r;

  assign en       = !(vld_r[NST-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // stage 0: heading and target vector, zero-length check
  logic signed [CW-1:0] a_in [3];
  logic signed [CW-1:0] p_in [3];
  logic signed [CW-1:0] t_in [3];
  logic signed [CW-1:0] s0_a_r [3];
  logic signed [BW-1:0] s0_b_r [3];
  logic                 s0_deg_r;
  logic                 a_zero;
  logic                 b_zero;

  assign a_in[0] = in_dir_x;
  assign a_in[1] = in_dir_y;
  assign a_in[2] = in_dir_z;
  assign p_in[0] = in_pos_x;
  assign p_in[1] = in_pos_y;
  assign p_in[2] = in_pos_z;
  assign t_in[0] = in_target_x;
  assign t_in[1] = in_target_y;
  assign t_in[2] = in_target_z;

  assign a_zero = (in_dir_x == '0) && (in_dir_y == '0) && (in_dir_z == '0);
  assign b_zero = (in_target_x == in_pos_x) && (in_target_y == in_pos_y) &&
                  (in_target_z == in_pos_z);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_a_r[i] <= a_in[i];
        s0_b_r[i] <= BW'(t_in[i]) - BW'(p_in[i]);
      end
      s0_deg_r <= a_zero || b_zero;
    end
  end

  // stage 1: magnitudes and common shift of each vector
  logic [CW-1:0]   amag [3];
  logic [BW-1:0]   bmag [3];
  logic [CW-1:0]   a_or;
  logic [BW-1:0]   b_or;
  logic [CW-1:0]   s1_amag_r [3];
  logic [BW-1:0]   s1_bmag_r [3];
  logic [2:0]      s1_aneg_r;
  logic [2:0]      s1_bneg_r;
  logic [SH_W-1:0] s1_ash_r;
  logic [SH_W-1:0] s1_bsh_r;
  logic            s1_deg_r;

  always_comb begin
    a_or = '0;
    b_or = '0;
    for (int i = 0; i < 3; i++) begin
      amag[i] = s0_a_r[i][CW-1] ? CW'(-s0_a_r[i]) : CW'(s0_a_r[i]);
      bmag[i] = s0_b_r[i][BW-1] ? BW'(-s0_b_r[i]) : BW'(s0_b_r[i]);
      a_or    = a_or | amag[i];
      b_or    = b_or | bmag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_amag_r[i] <= amag[i];
        s1_bmag_r[i] <= bmag[i];
        s1_aneg_r[i] <= s0_a_r[i][CW-1];
        s1_bneg_r[i] <= s0_b_r[i][BW-1];
      end
      s1_ash_r <= norm_shift(MW'(a_or));
      s1_bsh_r <= norm_shift(MW'(b_or));
      s1_deg_r <= s0_deg_r;
    end
  end

  // stage 2: scaled vectors, magnitude truncated toward zero
  logic signed [SW-1:0] s2_a_r [3];
  logic signed [SW-1:0] s2_b_r [3];
  logic                 s2_deg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_a_r[i] <= s1_aneg_r[i] ? -SW'(s1_amag_r[i] >> s1_ash_r)
                                  :  SW'(s1_amag_r[i] >> s1_ash_r);
        s2_b_r[i] <= s1_bneg_r[i] ? -SW'(s1_bmag_r[i] >> s1_bsh_r)
                                  :  SW'(s1_bmag_r[i] >> s1_bsh_r);
      end
      s2_deg_r <= s1_deg_r;
    end
  end

  // stage 3: the nine component products
  logic signed [PW-1:0] s3_p_r [9];
  logic                 s3_deg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p_r[0] <= s2_a_r[1] * s2_b_r[2];
      s3_p_r[1] <= s2_a_r[2] * s2_b_r[1];
      s3_p_r[2] <= s2_a_r[2] * s2_b_r[0];
      s3_p_r[3] <= s2_a_r[0] * s2_b_r[2];
      s3_p_r[4] <= s2_a_r[0] * s2_b_r[1];
      s3_p_r[5] <= s2_a_r[1] * s2_b_r[0];
      s3_p_r[6] <= s2_a_r[0] * s2_b_r[0];
      s3_p_r[7] <= s2_a_r[1] * s2_b_r[1];
      s3_p_r[8] <= s2_a_r[2] * s2_b_r[2];
      s3_deg_r  <= s2_deg_r;
    end
  end

  // stage 4: cross product and dot product
  logic signed [WW-1:0] s4_w_r [4];
  logic                 s4_deg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_w_r[0] <= WW'(s3_p_r[0]) - WW'(s3_p_r[1]);
      s4_w_r[1] <= WW'(s3_p_r[2]) - WW'(s3_p_r[3]);
      s4_w_r[2] <= WW'(s3_p_r[4]) - WW'(s3_p_r[5]);
      s4_w_r[3] <= WW'(s3_p_r[6]) + WW'(s3_p_r[7]) + WW'(s3_p_r[8]);
      s4_deg_r  <= s3_deg_r;
    end
  end

  // stage 5: magnitudes and common shift of cross and dot
  logic [WMW-1:0]  wmag [4];
  logic [WMW-1:0]  w_or;
  logic [WMW-1:0]  s5_wmag_r [4];
  logic            s5_xneg_r;
  logic [SH_W-1:0] s5_sh_r;
  logic            s5_deg_r;

  always_comb begin
    w_or = '0;
    for (int i = 0; i < 4; i++) begin
      wmag[i] = s4_w_r[i][WW-1] ? WMW'(-s4_w_r[i]) : WMW'(s4_w_r[i]);
      w_or    = w_or | wmag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s5_wmag_r[i] <= wmag[i];
      end
      s5_xneg_r <= s4_w_r[3][WW-1];
      s5_sh_r   <= norm_shift(MW'(w_or));
      s5_deg_r  <= s4_deg_r;
    end
  end

  // stage 6: scaled cross magnitudes and signed dot
  logic [NORM_BITS-1:0] s6_m_r [3];
  logic signed [SW-1:0] s6_x_r;
  logic                 s6_deg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_m_r[i] <= NORM_BITS'(s5_wmag_r[i] >> s5_sh_r);
      end
      s6_x_r   <= s5_xneg_r ? -SW'(s5_wmag_r[3] >> s5_sh_r)
                            :  SW'(s5_wmag_r[3] >> s5_sh_r);
      s6_deg_r <= s5_deg_r;
    end
  end

  // stage 7: squares of the cross components
  logic [SQW-1:0]       s7_sq_r [3];
  logic signed [SW-1:0] s7_x_r;
  logic                 s7_deg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_sq_r[i] <= s6_m_r[i] * s6_m_r[i];
      end
      s7_x_r   <= s6_x_r;
      s7_deg_r <= s6_deg_r;
    end
  end

  // square root pipeline, one result bit per stage
  logic [RTW-1:0]       sr_n_r   [SQRT_STEPS+1];
  logic [RTW-1:0]       sr_q_r   [SQRT_STEPS+1];
  logic signed [SW-1:0] sr_x_r   [SQRT_STEPS+1];
  logic                 sr_deg_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_n_r[0]   <= RTW'(s7_sq_r[0]) + RTW'(s7_sq_r[1]) + RTW'(s7_sq_r[2]);
      sr_q_r[0]   <= '0;
      sr_x_r[0]   <= s7_x_r;
      sr_deg_r[0] <= s7_deg_r;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [RTW-1:0] BIT = RTW'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [RTW-1:0] trial;
    logic           take;

    assign trial = sr_q_r[j] + BIT;
    assign take  = sr_n_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sr_n_r[j+1]   <= take ? sr_n_r[j] - trial : sr_n_r[j];
        sr_q_r[j+1]   <= take ? (sr_q_r[j] >> 1) + BIT : sr_q_r[j] >> 1;
        sr_x_r[j+1]   <= sr_x_r[j];
        sr_deg_r[j+1] <= sr_deg_r[j];
      end
    end
  end

  // quadrant fold and prescale into the cordic
  logic [YW-1:0]         y_root;
  logic signed [CDW-1:0] cr_x_r   [CORDIC_ITERS+1];
  logic signed [CDW-1:0] cr_y_r   [CORDIC_ITERS+1];
  logic signed [ANG_W-1:0] cr_z_r [CORDIC_ITERS+1];
  logic                  cr_swp_r [CORDIC_ITERS+1];
  logic                  cr_deg_r [CORDIC_ITERS+1];

  assign y_root = YW'(sr_q_r[SQRT_STEPS]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sr_x_r[SQRT_STEPS] < 0) begin
        cr_x_r[0] <= CDW'(y_root) << PRESCALE;
        cr_y_r[0] <= (-CDW'(sr_x_r[SQRT_STEPS])) << PRESCALE;
      end else begin
        cr_x_r[0] <= CDW'(sr_x_r[SQRT_STEPS]) << PRESCALE;
        cr_y_r[0] <= CDW'(y_root) << PRESCALE;
      end
      cr_z_r[0]   <= '0;
      cr_swp_r[0] <= sr_x_r[SQRT_STEPS] < 0;
      cr_deg_r[0] <= sr_deg_r[SQRT_STEPS];
    end
  end

  // vectoring cordic, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    localparam logic signed [ANG_W-1:0] STEP = step_angle(i);
    logic signed [CDW-1:0] dx;
    logic signed [CDW-1:0] dy;

    assign dx = cr_y_r[i] >>> i;
    assign dy = cr_x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cr_y_r[i][CDW-1]) begin
          cr_x_r[i+1] <= cr_x_r[i] + dx;
          cr_y_r[i+1] <= cr_y_r[i] - dy;
          cr_z_r[i+1] <= cr_z_r[i] + STEP;
        end else begin
          cr_x_r[i+1] <= cr_x_r[i] - dx;
          cr_y_r[i+1] <= cr_y_r[i] + dy;
          cr_z_r[i+1] <= cr_z_r[i] - STEP;
        end
        cr_swp_r[i+1] <= cr_swp_r[i];
        cr_deg_r[i+1] <= cr_deg_r[i];
      end
    end
  end

  // total angle clamped to 0..pi
  localparam logic signed [ANG_W-1:0] HALF_PI_A = ANG_W'(HALF_PI_S);
  localparam logic signed [ANG_W-1:0] PI_A      = ANG_W'(PI_S);
  logic signed [ANG_W-1:0] tot;
  logic [PI_W-1:0]         cl_ang_r;
  logic                    cl_deg_r;

  assign tot = cr_z_r[CORDIC_ITERS] + (cr_swp_r[CORDIC_ITERS] ? HALF_PI_A : '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (tot < 0) begin
        cl_ang_r <= '0;
      end else if (tot > PI_A) begin
        cl_ang_r <= PI_S;
      end else begin
        cl_ang_r <= PI_W'(tot);
      end
      cl_deg_r <= cr_deg_r[CORDIC_ITERS];
    end
  end

  // radians to degrees: divide by pi with a reciprocal multiply and one correction
  localparam int RC_SH = NW - 32;
  localparam int RC_T  = 34;
  localparam int RCP_W = 20;
  localparam int REM_W = PI_W + 1;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << (RC_T + RC_SH)) / 64'(PI_S));
  localparam logic [REM_W-1:0] PI_R  = REM_W'(PI_S);
  logic [NW-1:0]    dv_n_r;
  logic             dv_deg_r;
  logic [NW-1:0]    dq_n_r;
  logic [DEG_W-1:0] dq_q_r;
  logic             dq_deg_r;
  logic [REM_W-1:0] dr_rem_r;
  logic [DEG_W-1:0] dr_q_r;
  logic             dr_deg_r;
  logic [DEG_W-1:0] dd_q_r;
  logic             dd_deg_r;

  // scaled numerator with half of pi for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      dv_n_r   <= NW'(cl_ang_r) * NW'(DEG_SCALE) + NW'(PI_S >> 1);
      dv_deg_r <= cl_deg_r;
    end
  end

  // quotient estimate, never high and at most one low
  always_ff @(posedge clk) begin
    if (en) begin
      dq_q_r   <= DEG_W'((64'(dv_n_r[NW-1:RC_SH]) * 64'(RECIP)) >> RC_T);
      dq_n_r   <= dv_n_r;
      dq_deg_r <= dv_deg_r;
    end
  end

  // remainder left by the estimate
  always_ff @(posedge clk) begin
    if (en) begin
      dr_rem_r <= REM_W'(dq_n_r - NW'(dq_q_r) * NW'(PI_S));
      dr_q_r   <= dq_q_r;
      dr_deg_r <= dq_deg_r;
    end
  end

  // correct the estimate by one where the remainder reaches pi
  always_ff @(posedge clk) begin
    if (en) begin
      dd_q_r   <= dr_q_r + DEG_W'(dr_rem_r >= PI_R);
      dd_deg_r <= dr_deg_r;
    end
  end

  // result transaction
  assign out_valid      = vld_r[NST-1];
  assign out_degenerate = dd_deg_r;
  assign out_angle_deg  = dd_deg_r ? '0 : ANGLE_W'(dd_q_r);

endmodule
